// ===== design/vertex_radial_ripple_displace_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef VERTEX_RADIAL_RIPPLE_DISPLACE_UNIT_DEFINES_SVH
`define VERTEX_RADIAL_RIPPLE_DISPLACE_UNIT_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define VRRD_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("vrrd check failed");

// next-cycle implication, ignored while reset is high
`define VRRD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("vrrd check failed");

`endif

// ===== design/vrrd_pkg.sv =====
// shared widths, register indexes and constants of the ripple displacement unit
package vrrd_pkg;

  localparam int COORD_W    = 32;
  localparam int TIME_W     = 31;
  localparam int RADIUS_W   = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVELENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd5;

  // pi/2 in Q30, seed of the sine table
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== design/vrrd_if.sv =====
// valid/ready channel interfaces of the ripple displacement unit
interface vrrd_in_if;
  import vrrd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [TIME_W-1:0]         elapsed_time;
  modport source (output valid, vertex_x, vertex_y, elapsed_time, input ready);
  modport sink (input valid, vertex_x, vertex_y, elapsed_time, output ready);
endinterface

interface vrrd_out_if;
  import vrrd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      passed_through;
  modport source (output valid, out_x, out_y, passed_through, input ready);
  modport sink (input valid, out_x, out_y, passed_through, output ready);
endinterface

interface vrrd_cfg_if;
  import vrrd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/vertex_radial_ripple_displace_unit.sv =====
// radial ripple vertex displacement, fully pipelined
//
//   channel  | dir | payload
//   in_ch    | in  | vertex_x, vertex_y, elapsed_time
//   out_ch   | out | out_x, out_y, passed_through
//   cfg_ch   | in  | index, data (always ready)
//
// one vertex per clock while the output is not stalled; most stages are the
// bit-serial square root and the radix-2 divider stages.
// synchronous reset clears the valid bits and the configuration registers to zero.
// a stalled output freezes the whole pipe; input ready is low only while the
// last stage holds an item that is not taken.
module vertex_radial_ripple_displace_unit #(
  parameter int FRAC_BITS        = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst,
  vrrd_in_if.sink         in_ch,
  vrrd_out_if.source      out_ch,
  vrrd_cfg_if.sink        cfg_ch
);
  import vrrd_pkg::*;

  localparam int FB         = FRAC_BITS;
  localparam int D          = SINE_TABLE_DEPTH;
  localparam int IDX_W      = $clog2(D + 1);
  localparam int POS_W      = $clog2(4 * D);
  localparam int NEAR_LIMIT = (1 << FB) / 10000;

  // stage map
  localparam int SQ_FIRST = 3;
  localparam int DIV_INIT = SQ_FIRST + 32;
  localparam int QA_FIRST = DIV_INIT + 1;
  localparam int QA_N     = 32 + FB;
  localparam int PH       = QA_FIRST + QA_N;
  localparam int SEL      = PH + 1;
  localparam int SIN      = PH + 2;
  localparam int M1       = PH + 3;
  localparam int M2       = PH + 4;
  localparam int PX       = PH + 5;
  localparam int OD_FIRST = PH + 6;
  localparam int LAST     = OD_FIRST + 32;

  typedef struct packed {
    logic [31:0]      vx;
    logic [31:0]      vy;
    logic [31:0]      dx;
    logic [31:0]      dy;
    logic [FB-1:0]    tterm;
    logic [63:0]      sqx;
    logic [63:0]      sqy;
    logic [63:0]      rad;
    logic [35:0]      srem;
    logic [31:0]      root;
    logic             pass;
    logic             att_full;
    logic             att_zero;
    logic [31:0]      arem;
    logic [FB-1:0]    aq;
    logic [31:0]      wrem;
    logic [31+FB:0]   wnum;
    logic [FB-1:0]    wq;
    logic [FB-1:0]    phase;
    logic [FB:0]      att;
    logic [IDX_W-1:0] sidx;
    logic             sneg;
    logic [FB:0]      smag;
    logic             mneg;
    logic [31:0]      mmag;
    logic [31:0]      dmag;
    logic             dneg;
    logic [31:0]      xrem;
    logic [31:0]      xnum;
    logic [31:0]      xq;
    logic [31:0]      yrem;
    logic [31:0]      ynum;
    logic [31:0]      yq;
    logic [31:0]      rx;
    logic [31:0]      ry;
  } item_t;

  // configuration registers
  logic signed [31:0] center_x, center_y, ripple_wavelength, ripple_speed, ripple_amplitude;
  logic [RADIUS_W-1:0] falloff_radius;
  logic [31:0] wl_mag, amp_mag;

  item_t         p [0:LAST];
  logic [LAST:0] v;
  logic          en;

  // sine quarter table, built at elaboration
  function automatic logic [FB:0] sine_entry(input int unsigned i);
    logic [63:0] x, x2, term;
    logic signed [63:0] sum;
    x = HALF_PI_Q30 * 64'(i) / D;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = (term * x2 / 6) >> 30;   sum = sum - $signed(term);
    term = (term * x2 / 20) >> 30;  sum = sum + $signed(term);
    term = (term * x2 / 42) >> 30;  sum = sum - $signed(term);
    term = (term * x2 / 72) >> 30;  sum = sum + $signed(term);
    term = (term * x2 / 110) >> 30; sum = sum - $signed(term);
    term = (term * x2 / 156) >> 30; sum = sum + $signed(term);
    term = (term * x2 / 210) >> 30; sum = sum - $signed(term);
    term = (term * x2 / 272) >> 30; sum = sum + $signed(term);
    if (sum < 0) sum = 0;
    sum = (sum + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    if (sum > (64'sd1 <<< FB)) sum = 64'sd1 <<< FB;
    return sum[FB:0];
  endfunction

  logic [FB:0] sine_rom [0:D];
  for (genvar g = 0; g <= D; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] a);
    if (a[32] != a[31]) return a[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return a[31:0];
  endfunction

  function automatic logic [31:0] sat34(input logic [33:0] a);
    if ($signed(a) > 34'sh0_7fff_ffff) return 32'h7fff_ffff;
    if ($signed(a) < -34'sh0_8000_0000) return 32'h8000_0000;
    return a[31:0];
  endfunction

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x          <= '0;
      center_y          <= '0;
      falloff_radius    <= '0;
      ripple_wavelength <= '0;
      ripple_speed      <= '0;
      ripple_amplitude  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CENTER_X:   center_x          <= cfg_ch.data;
        CFG_CENTER_Y:   center_y          <= cfg_ch.data;
        CFG_RADIUS:     falloff_radius    <= cfg_ch.data[RADIUS_W-1:0];
        CFG_WAVELENGTH: ripple_wavelength <= cfg_ch.data;
        CFG_SPEED:      ripple_speed      <= cfg_ch.data;
        CFG_AMPLITUDE:  ripple_amplitude  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign wl_mag  = mag32(ripple_wavelength);
  assign amp_mag = mag32(ripple_amplitude);

  // pipe advances unless the last stage is stalled
  assign en          = !v[LAST] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAST-1:0], in_ch.valid};
    end
  end

  for (genvar s = 0; s <= LAST; s++) begin : g_stage
    item_t nx;

    if (s == 0) begin : g_off
      // offsets from the center and the time term
      logic signed [63:0] tprod;
      always_comb begin
        nx = '0;
        nx.vx = in_ch.vertex_x;
        nx.vy = in_ch.vertex_y;
        nx.dx = sat33({in_ch.vertex_x[31], in_ch.vertex_x} - {center_x[31], center_x});
        nx.dy = sat33({in_ch.vertex_y[31], in_ch.vertex_y} - {center_y[31], center_y});
        tprod = $signed({1'b0, in_ch.elapsed_time}) * ripple_speed;
        nx.tterm = tprod[2*FB-1:FB];
      end
    end else if (s == 1) begin : g_sq
      // squared offsets
      always_comb begin
        nx = p[s-1];
        nx.sqx = 64'(mag32(p[s-1].dx)) * 64'(mag32(p[s-1].dx));
        nx.sqy = 64'(mag32(p[s-1].dy)) * 64'(mag32(p[s-1].dy));
      end
    end else if (s == 2) begin : g_sum
      // radicand
      always_comb begin
        nx = p[s-1];
        nx.rad = p[s-1].sqx + p[s-1].sqy;
        nx.srem = '0;
        nx.root = '0;
      end
    end else if (s < DIV_INIT) begin : g_sqrt
      // one root bit per stage
      logic [35:0] sh, trial;
      always_comb begin
        nx = p[s-1];
        sh = {p[s-1].srem[33:0], p[s-1].rad[63:62]};
        trial = {2'b00, p[s-1].root, 2'b01};
        nx.rad = {p[s-1].rad[61:0], 2'b00};
        if (sh >= trial) begin
          nx.srem = sh - trial;
          nx.root = {p[s-1].root[30:0], 1'b1};
        end else begin
          nx.srem = sh;
          nx.root = {p[s-1].root[30:0], 1'b0};
        end
      end
    end else if (s == DIV_INIT) begin : g_dinit
      // pass-through decision and divider setup
      always_comb begin
        nx = p[s-1];
        nx.pass = (ripple_wavelength == 0) || (p[s-1].root <= 32'(NEAR_LIMIT));
        nx.att_full = (falloff_radius == 0);
        nx.att_zero = (p[s-1].root >= {1'b0, falloff_radius});
        nx.arem = p[s-1].root;
        nx.aq = '0;
        nx.wrem = '0;
        nx.wnum = {p[s-1].root, {FB{1'b0}}};
        nx.wq = '0;
      end
    end else if (s < PH) begin : g_div
      // phase divider bit, and attenuation divider bit in the first stages
      logic [32:0] wsh;
      logic [31:0] ash;
      always_comb begin
        nx = p[s-1];
        wsh = {p[s-1].wrem, p[s-1].wnum[31+FB]};
        nx.wnum = {p[s-1].wnum[30+FB:0], 1'b0};
        if (wsh >= {1'b0, wl_mag}) begin
          nx.wrem = 32'(wsh - {1'b0, wl_mag});
          nx.wq = {p[s-1].wq[FB-2:0], 1'b1};
        end else begin
          nx.wrem = wsh[31:0];
          nx.wq = {p[s-1].wq[FB-2:0], 1'b0};
        end
        ash = {p[s-1].arem[30:0], 1'b0};
        if (s - QA_FIRST < FB) begin
          if (ash >= {1'b0, falloff_radius}) begin
            nx.arem = ash - {1'b0, falloff_radius};
            nx.aq = {p[s-1].aq[FB-2:0], 1'b1};
          end else begin
            nx.arem = ash;
            nx.aq = {p[s-1].aq[FB-2:0], 1'b0};
          end
        end
      end
    end else if (s == PH) begin : g_phase
      // phase in turns and attenuation
      logic [FB-1:0] pa;
      always_comb begin
        nx = p[s-1];
        pa = ripple_wavelength[31] ? FB'(-p[s-1].wq) : p[s-1].wq;
        nx.phase = pa + p[s-1].tterm;
        if (p[s-1].att_full) nx.att = (FB+1)'(1) << FB;
        else if (p[s-1].att_zero) nx.att = '0;
        else nx.att = ((FB+1)'(1) << FB) - {1'b0, p[s-1].aq};
      end
    end else if (s == SEL) begin : g_sel
      // quadrant and table index
      logic [FB+POS_W-1:0] pfull;
      logic [POS_W-1:0] pos, r;
      logic [1:0] q;
      always_comb begin
        nx = p[s-1];
        pfull = (FB+POS_W)'(p[s-1].phase) * (FB+POS_W)'(4 * D);
        pos = pfull[FB+POS_W-1:FB];
        priority if (pos >= POS_W'(3 * D)) begin
          q = 2'd3; r = pos - POS_W'(3 * D);
        end else if (pos >= POS_W'(2 * D)) begin
          q = 2'd2; r = pos - POS_W'(2 * D);
        end else if (pos >= POS_W'(D)) begin
          q = 2'd1; r = pos - POS_W'(D);
        end else begin
          q = 2'd0; r = pos;
        end
        nx.sidx = q[0] ? IDX_W'(D) - r[IDX_W-1:0] : r[IDX_W-1:0];
        nx.sneg = q[1];
      end
    end else if (s == SIN) begin : g_sin
      // table read
      always_comb begin
        nx = p[s-1];
        nx.smag = sine_rom[p[s-1].sidx];
      end
    end else if (s == M1) begin : g_m1
      // sine times amplitude
      logic [FB+32:0] prod;
      always_comb begin
        nx = p[s-1];
        prod = (FB+33)'(p[s-1].smag) * (FB+33)'(amp_mag);
        nx.mmag = prod[FB+31:FB];
        nx.mneg = p[s-1].sneg != ripple_amplitude[31];
      end
    end else if (s == M2) begin : g_m2
      // attenuation and saturation of the displacement
      logic [FB+32:0] prod;
      logic [31:0] val;
      always_comb begin
        nx = p[s-1];
        prod = (FB+33)'(p[s-1].mmag) * (FB+33)'(p[s-1].att);
        val = prod[FB+31:FB];
        nx.dneg = p[s-1].mneg && (val != 0);
        nx.dmag = (!p[s-1].mneg && val[31]) ? 32'h7fff_ffff : val;
      end
    end else if (s == PX) begin : g_px
      // per-axis numerators
      logic [63:0] px, py;
      always_comb begin
        nx = p[s-1];
        px = 64'(mag32(p[s-1].dx)) * 64'(p[s-1].dmag);
        py = 64'(mag32(p[s-1].dy)) * 64'(p[s-1].dmag);
        nx.xrem = px[63:32];
        nx.xnum = px[31:0];
        nx.xq = '0;
        nx.yrem = py[63:32];
        nx.ynum = py[31:0];
        nx.yq = '0;
      end
    end else if (s < LAST) begin : g_odiv
      // one quotient bit per axis per stage
      logic [32:0] xs, ys;
      always_comb begin
        nx = p[s-1];
        xs = {p[s-1].xrem, p[s-1].xnum[31]};
        ys = {p[s-1].yrem, p[s-1].ynum[31]};
        nx.xnum = {p[s-1].xnum[30:0], 1'b0};
        nx.ynum = {p[s-1].ynum[30:0], 1'b0};
        if (xs >= {1'b0, p[s-1].root}) begin
          nx.xrem = 32'(xs - {1'b0, p[s-1].root});
          nx.xq = {p[s-1].xq[30:0], 1'b1};
        end else begin
          nx.xrem = xs[31:0];
          nx.xq = {p[s-1].xq[30:0], 1'b0};
        end
        if (ys >= {1'b0, p[s-1].root}) begin
          nx.yrem = 32'(ys - {1'b0, p[s-1].root});
          nx.yq = {p[s-1].yq[30:0], 1'b1};
        end else begin
          nx.yrem = ys[31:0];
          nx.yq = {p[s-1].yq[30:0], 1'b0};
        end
      end
    end else begin : g_out
      // apply the shift or pass the vertex through
      logic [32:0] ox, oy;
      always_comb begin
        nx = p[s-1];
        ox = (p[s-1].dx[31] != p[s-1].dneg) ? 33'(-{1'b0, p[s-1].xq}) : {1'b0, p[s-1].xq};
        oy = (p[s-1].dy[31] != p[s-1].dneg) ? 33'(-{1'b0, p[s-1].yq}) : {1'b0, p[s-1].yq};
        if (p[s-1].pass) begin
          nx.rx = p[s-1].vx;
          nx.ry = p[s-1].vy;
        end else begin
          nx.rx = sat34({{2{p[s-1].vx[31]}}, p[s-1].vx} + {ox[32], ox});
          nx.ry = sat34({{2{p[s-1].vy[31]}}, p[s-1].vy} + {oy[32], oy});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) p[s] <= nx;
    end
  end

  // result
  assign out_ch.valid          = v[LAST];
  assign out_ch.out_x          = p[LAST].rx;
  assign out_ch.out_y          = p[LAST].ry;
  assign out_ch.passed_through = p[LAST].pass;

endmodule

// ===== design/vrrd_checker.sv =====
// port-level checks of the ripple displacement unit, bound to the top level
`include "vertex_radial_ripple_displace_unit_defines.svh"

module vrrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic        passed_through
);
  // a stalled result stays offered
  `VRRD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a stalled result keeps its payload
  `VRRD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_x) && $stable(out_y) && $stable(passed_through))
  // an empty output stage never blocks the input
  `VRRD_ASSERT_NOW(a_in_free, clk, rst, !out_valid, in_ready)
  // the pipe comes out of reset empty
  `VRRD_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid)
endmodule

bind vertex_radial_ripple_displace_unit vrrd_checker u_vrrd_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_x(out_ch.out_x),
  .out_y(out_ch.out_y),
  .passed_through(out_ch.passed_through)
);

// ===== sim/tb_top.sv =====
// self-checking testbench of the radial ripple vertex displacement unit
module tb_top;
  import vrrd_pkg::*;

  localparam int FRAC       = 16;
  localparam int DEPTH      = 1024;
  localparam longint ONE_Q  = 64'sd1 << FRAC;
  localparam longint NEAR   = ONE_Q / 10000;
  localparam int LATENCY    = 2 * 32 + FRAC + 43;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic [TIME_W-1:0]         t;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic                      pass;
  } moved_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vrrd_in_if  in_ch();
  vrrd_out_if out_ch();
  vrrd_cfg_if cfg_ch();

  vertex_radial_ripple_displace_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // predictor copy of the registers
  longint ctr_x, ctr_y, radius, wavelen, speed, amp;
  longint sine_q [0:DEPTH];

  vertex_t pending_q [$];
  moved_t  moved_q [$];
  int      errors = 0;
  int      cycles = 0;
  int      taken = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // quarter-wave sine table from a fixed-point series
  function automatic void build_sine();
    longint unsigned x, x2, term;
    longint sum;
    for (int i = 0; i <= DEPTH; i++) begin
      x = HALF_PI_Q30 * longint'(i) / DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = term * x2 / longint'((2 * k) * (2 * k + 1));
        term = term >> 30;
        if (k & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
      if (sum > ONE_Q) sum = ONE_Q;
      sine_q[i] = sum;
    end
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    longint unsigned p;
    p = (absval(a) * absval(b)) >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sine_of_turn(longint unsigned ph);
    longint unsigned pos, q, r;
    longint v;
    pos = (ph * (4 * DEPTH)) >> FRAC;
    q = (pos / DEPTH) & 3;
    r = pos % DEPTH;
    v = q[0] ? sine_q[DEPTH - r] : sine_q[r];
    return q[1] ? -v : v;
  endfunction

  // displaced vertex for one rest vertex under the current registers
  function automatic moved_t displace(vertex_t v);
    moved_t res;
    longint vx, vy, dx, dy, att, s, disp, sx, sy;
    longint unsigned span, ratio, qa, pa, pb;
    vx = longint'(v.vx);
    vy = longint'(v.vy);
    dx = clip32(vx - ctr_x);
    dy = clip32(vy - ctr_y);
    span = floor_sqrt(absval(dx) * absval(dx) + absval(dy) * absval(dy));
    if (wavelen == 0 || span <= NEAR) begin
      res.ox = v.vx;
      res.oy = v.vy;
      res.pass = 1'b1;
      return res;
    end
    att = ONE_Q;
    if (radius > 0) begin
      ratio = (span << FRAC) / longint'(radius);
      if (ratio > ONE_Q) ratio = ONE_Q;
      att = ONE_Q - longint'(ratio);
    end
    qa = (span << FRAC) / absval(wavelen);
    pa = (wavelen < 0) ? 64'd0 - qa : qa;
    pb = longint'(longint'({33'd0, v.t}) * speed) >> FRAC;
    s = sine_of_turn((pa + pb) & (ONE_Q - 1));
    disp = clip32(fix_mul(fix_mul(s, amp), att));
    sx = longint'(absval(dx) * absval(disp) / span);
    sy = longint'(absval(dy) * absval(disp) / span);
    if ((dx < 0) != (disp < 0)) sx = -sx;
    if ((dy < 0) != (disp < 0)) sy = -sy;
    res.ox = 32'(clip32(vx + sx));
    res.oy = 32'(clip32(vy + sy));
    res.pass = 1'b0;
    return res;
  endfunction

  function automatic bit idle_roll();
    if (cycles > 3000 && cycles < 6000) return 1'b0;
    return $urandom_range(99) < 32;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // input driver, prediction taken at acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.vertex_x <= '0;
      in_ch.vertex_y <= '0;
      in_ch.elapsed_time <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        moved_q.insert(moved_q.size(),
                       displace({in_ch.vertex_x, in_ch.vertex_y, in_ch.elapsed_time}));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && !idle_roll()) begin
          vertex_t nv;
          nv = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.vertex_x <= nv.vx;
          in_ch.vertex_y <= nv.vy;
          in_ch.elapsed_time <= nv.t;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random backpressure and one long hold-off
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        taken <= taken + 1;
        if (moved_q.size() == 0) begin
          $display("%0t unexpected item: x %0d y %0d pass %0b", $time,
                   out_ch.out_x, out_ch.out_y, out_ch.passed_through);
          errors = errors + 1;
        end else begin
          moved_t w;
          w = moved_q.pop_front();
          if (w.ox !== out_ch.out_x) begin
            $display("%0t out_x expected %0d actual %0d", $time, w.ox, out_ch.out_x);
            errors = errors + 1;
          end
          if (w.oy !== out_ch.out_y) begin
            $display("%0t out_y expected %0d actual %0d", $time, w.oy, out_ch.out_y);
            errors = errors + 1;
          end
          if (w.pass !== out_ch.passed_through) begin
            $display("%0t passed_through expected %0b actual %0b", $time, w.pass,
                     out_ch.passed_through);
            errors = errors + 1;
          end
        end
      end
      if (!hold_done && taken >= 300) begin
        hold_done <= 1'b1;
        hold_cnt <= HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_roll();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    unique case (idx)
      CFG_CENTER_X:   ctr_x = longint'($signed(val));
      CFG_CENTER_Y:   ctr_y = longint'($signed(val));
      CFG_RADIUS:     radius = longint'({33'd0, val[30:0]});
      CFG_WAVELENGTH: wavelen = longint'($signed(val));
      CFG_SPEED:      speed = longint'($signed(val));
      CFG_AMPLITUDE:  amp = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] rad,
                         logic [31:0] wl, logic [31:0] sp, logic [31:0] am);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_WAVELENGTH, wl);
    write_reg(CFG_SPEED, sp);
    write_reg(CFG_AMPLITUDE, am);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || moved_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [30:0] t);
    pending_q.insert(pending_q.size(), {x, y, t});
  endtask

  // mostly near-center values, some extremes and full-range noise
  function automatic logic [31:0] pick_coord(longint base);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    if (sel == 1) return $urandom;
    if (sel == 2) return 32'(base + $signed($urandom_range(20)) - 10);
    return 32'(base + ($signed($urandom) >>> $urandom_range(24, 8)));
  endfunction

  function automatic logic [31:0] pick_param();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    if (sel == 1) return $urandom;
    return $signed($urandom) >>> $urandom_range(20, 8);
  endfunction

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    ctr_x = 0; ctr_y = 0; radius = 0; wavelen = 0; speed = 0; amp = 0;
    build_sine();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: zero wavelength passes everything through
    add_vertex(32'h00030000, 32'hfffd0000, 31'h12345);
    add_vertex(32'h7fffffff, 32'h80000000, 31'h7fffffff);
    drain();

    // directed: center, near-center limit, extremes of fields
    set_all(32'h00010000, 32'hffff0000, 32'h00080000, 32'h00020000, 32'h00008000,
            32'h00004000);
    add_vertex(32'h00010000, 32'hffff0000, 31'd0);
    add_vertex(32'h00010006, 32'hffff0000, 31'd100);
    add_vertex(32'h00010007, 32'hffff0000, 31'd100);
    add_vertex(32'h00010004, 32'hfffefffc, 31'd7);
    add_vertex(32'h00030000, 32'hffff0000, 31'd0);
    add_vertex(32'h00010000, 32'h00020000, 31'h7fffffff);
    add_vertex(32'h00100000, 32'h00100000, 31'h00010000);
    add_vertex(32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    add_vertex(32'h80000000, 32'h80000000, 31'd0);
    add_vertex(32'h80000000, 32'h7fffffff, 31'h40000000);
    add_vertex(32'hffffffff, 32'h00000000, 31'h2aaaaaaa);
    drain();

    // directed: negative wavelength, extreme speed and amplitude, no falloff
    set_all(32'h80000000, 32'h7fffffff, 32'h00000000, 32'hfffe0000, 32'h7fffffff,
            32'h80000000);
    add_vertex(32'h7fffffff, 32'h80000000, 31'h7fffffff);
    add_vertex(32'h00000000, 32'h00000000, 31'h55555555);
    add_vertex(32'h80000005, 32'h7fffffff, 31'd1);
    add_vertex(32'h80100000, 32'h7ff00000, 31'h00008000);
    drain();
    set_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
            32'h7fffffff);
    add_vertex(32'h80000000, 32'h7fffffff, 31'h7fffffff);
    add_vertex(32'h00000000, 32'h00000000, 31'h00000001);
    add_vertex(32'h7ff00000, 32'h80100000, 31'h00ff00ff);
    drain();

    // random phases with fresh register settings; one long phase fills the pipe
    for (int ph = 0; ph < 10; ph++) begin
      logic [31:0] cx, cy, wl;
      cx = ($urandom_range(3) == 0) ? $urandom : $signed($urandom) >>> 12;
      cy = ($urandom_range(3) == 0) ? $urandom : $signed($urandom) >>> 12;
      wl = pick_param();
      if (ph == 3) wl = '0;
      else if (wl == 0) wl = 32'h00010000;
      set_all(cx, cy, ($urandom_range(4) == 0) ? 32'd0 : pick_param() & 32'h7fffffff,
              wl, pick_param(), pick_param());
      for (int n = 0; n < ((ph == 5) ? 250 : 55); n++)
        add_vertex(pick_coord($signed(cx)), pick_coord($signed(cy)),
                   $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1 << 20)));
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
